// ===== hdl/signed_count_rle_decoder_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the signed-count run-length decoder
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SIGNED_COUNT_RLE_DECODER_CORE_DEFINES_SVH
`define SIGNED_COUNT_RLE_DECODER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCRLE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("decoder assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SCRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("decoder assertion failed");

`endif

// ===== hdl/scrle_pkg.sv =====
// ----------------------------------------------------------------------------
// Signed-count run-length decoder package
// Field widths, reset constants and the result token type.
// ----------------------------------------------------------------------------
package scrle_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned RUN_W           = 16;
  localparam int unsigned CAP_W           = 24;
  localparam int unsigned TOTAL_W         = 24;
  localparam int unsigned LENGTH_BITS_DEF = 24;

  localparam logic [CAP_W-1:0] CAP_RESET = 24'd737280;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic [RUN_W-1:0]   run_length;
    logic               finished;
    logic [TOTAL_W-1:0] total_written;
  } token_t;

endpackage

// ===== hdl/scrle_if.sv =====
// ----------------------------------------------------------------------------
// Signed-count run-length decoder channels
// Input byte, output token and capacity write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface scrle_in_if;
  import scrle_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface scrle_out_if;
  import scrle_pkg::*;
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte;
  logic [RUN_W-1:0]   run_length;
  logic               finished;
  logic [TOTAL_W-1:0] total_written;
  modport source (output valid, output out_byte, output run_length, output finished,
                  output total_written, input ready);
  modport sink   (input valid, input out_byte, input run_length, input finished,
                  input total_written, output ready);
endinterface

interface scrle_cfg_if;
  import scrle_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/signed_count_rle_decoder_core.sv =====
// ----------------------------------------------------------------------------
// Signed-count run-length decoder core
// Turns a compressed byte stream into (byte, length) tokens, at most one per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   : one compressed byte per request, in_last marks the final byte.
//   out_o  : tokens (out_byte, run_length, finished, total_written). A repeat
//            record gives one token of clipped length, each literal one token
//            of length one; the consumer expands repeats.
//   cfg_i  : writes output_capacity and restarts the decoder; always ready.
//            Write it only while no request is in flight.
// Throughput: one byte per cycle while out_o does not stall.
// Path: the input register feeds phase update, room clip and capacity
//   compare into the output register, which presents the result.
// Bytes that yield no output (count bytes that do not finish decoding, bytes
//   after finishing) never wait on the output channel.
// Reset: capacity returns to 737280 and the decoder waits for a count.
// Stall: a waiting token holds the output register; a byte that would emit then
//   waits in the input register and in_i.ready drops until out_o moves.
// ----------------------------------------------------------------------------
module signed_count_rle_decoder_core #(
  parameter int unsigned LENGTH_BITS = scrle_pkg::LENGTH_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  scrle_in_if.sink   in_i,
  scrle_out_if.source out_o,
  scrle_cfg_if.sink  cfg_i
);
  import scrle_pkg::*;

  `include "signed_count_rle_decoder_core_defines.svh"

  localparam int unsigned CW = (LENGTH_BITS > RUN_W) ? LENGTH_BITS : RUN_W;

  localparam logic [1:0] PH_CNT_LO  = 2'd0;
  localparam logic [1:0] PH_CNT_HI  = 2'd1;
  localparam logic [1:0] PH_REPEAT  = 2'd2;
  localparam logic [1:0] PH_LITERAL = 2'd3;

  // Configuration and decoder state
  logic [CAP_W-1:0]       cap_q;
  logic [1:0]             phase_q, phase_d;
  logic [BYTE_W-1:0]      cnt_lo_q, cnt_lo_d;
  logic [RUN_W-1:0]       lit_q, lit_d;
  logic [RUN_W-1:0]       rep_q, rep_d;
  logic [LENGTH_BITS-1:0] bw_q, bw_d;
  logic                   done_q, done_d;

  // Input register
  logic              in_valid_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_last_q;

  // Output register
  logic   out_valid_q;
  token_t out_tok_q;
  token_t tok;

  logic                   cfg_wr, in_acc, advance, emit, token;
  logic [LENGTH_BITS-1:0] cap_w, room;
  logic [CW-1:0]          rep_ext, room_ext, len_ext;
  logic [RUN_W-1:0]       raw;

  assign cfg_wr      = cfg_i.valid & cfg_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cap_w       = LENGTH_BITS'(cap_q);
  assign room        = cap_w - bw_q;
  assign rep_ext     = CW'(rep_q);
  assign room_ext    = CW'(room);
  assign len_ext     = (rep_ext > room_ext) ? room_ext : rep_ext;
  assign raw         = {in_byte_q, cnt_lo_q};

  always_comb begin
    phase_d  = phase_q;
    cnt_lo_d = cnt_lo_q;
    lit_d    = lit_q;
    rep_d    = rep_q;
    bw_d     = bw_q;
    done_d   = done_q;
    token    = 1'b0;
    emit     = 1'b0;
    tok      = '0;
    if (done_q) begin
      emit = 1'b0;
    end else if (bw_q >= cap_w) begin
      // Image already full when the byte arrives: drop it and finish.
      done_d = 1'b1;
      emit   = 1'b1;
    end else begin
      case (phase_q)
        PH_CNT_LO: begin
          cnt_lo_d = in_byte_q;
          phase_d  = PH_CNT_HI;
        end
        PH_CNT_HI: begin
          if (raw == '0) begin
            done_d  = 1'b1;
            phase_d = PH_CNT_LO;
          end else if (!raw[RUN_W-1]) begin
            rep_d   = raw;
            phase_d = PH_REPEAT;
          end else begin
            lit_d   = RUN_W'(0) - raw;
            phase_d = PH_LITERAL;
          end
        end
        PH_REPEAT: begin
          bw_d           = bw_q + LENGTH_BITS'(len_ext);
          token          = 1'b1;
          tok.out_byte   = in_byte_q;
          tok.run_length = RUN_W'(len_ext);
          rep_d          = '0;
          phase_d        = PH_CNT_LO;
        end
        default: begin
          bw_d           = bw_q + LENGTH_BITS'(1);
          token          = 1'b1;
          tok.out_byte   = in_byte_q;
          tok.run_length = RUN_W'(1);
          if (lit_q != '0) begin
            lit_d = lit_q - RUN_W'(1);
          end
          if (lit_q <= RUN_W'(1)) begin
            phase_d = PH_CNT_LO;
          end
        end
      endcase
      if (token && (bw_d >= cap_w)) begin
        done_d = 1'b1;
      end
      if (in_last_q) begin
        done_d = 1'b1;
      end
      emit = token | done_d;
    end
    tok.finished      = done_d;
    tok.total_written = TOTAL_W'(bw_d);
  end

  // A byte that yields nothing never waits for the output register.
  assign advance    = in_valid_q & (~emit | ~out_valid_q | out_o.ready);
  assign in_i.ready = ~in_valid_q | advance;
  assign in_acc     = in_i.valid & in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      phase_q <= PH_CNT_LO;
      lit_q   <= '0;
      rep_q   <= '0;
      cnt_lo_q <= '0;
      bw_q    <= '0;
      done_q  <= 1'b0;
    end else if (cfg_wr) begin
      cap_q    <= cfg_i.data;
      phase_q  <= PH_CNT_LO;
      lit_q    <= '0;
      rep_q    <= '0;
      cnt_lo_q <= '0;
      bw_q     <= '0;
      done_q   <= 1'b0;
    end else if (advance) begin
      phase_q  <= phase_d;
      lit_q    <= lit_d;
      rep_q    <= rep_d;
      cnt_lo_q <= cnt_lo_d;
      bw_q     <= bw_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= in_i.in_byte;
      in_last_q <= in_i.in_last;
    end
    if (advance && emit) begin
      out_tok_q <= tok;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_byte      = out_tok_q.out_byte;
  assign out_o.run_length    = out_tok_q.run_length;
  assign out_o.finished      = out_tok_q.finished;
  assign out_o.total_written = out_tok_q.total_written;

  // Nothing is produced once decoding has stopped.
  `SCRLE_ASSERT_SAME(a_no_token_after_done, clk_i, rst_ni, done_q, !emit)
  // A token marked finished leaves the decoder stopped.
  `SCRLE_ASSERT_NEXT(a_finished_sets_done, clk_i, rst_ni,
                     advance && emit && tok.finished && !cfg_wr, done_q)
  // The byte count never passes the capacity.
  `SCRLE_ASSERT_SAME(a_count_within_cap, clk_i, rst_ni, 1'b1, bw_q <= cap_w)
  // A literal record always has bytes still to come.
  `SCRLE_ASSERT_SAME(a_literal_nonzero, clk_i, rst_ni, phase_q == PH_LITERAL, lit_q != '0)

endmodule
